// ===== sv/zcbm_pkg.sv =====
`timescale 1ns / 1ps
package zcbm_pkg;
    localparam int MaxNodes   = 16;
    localparam int NodeW      = $clog2(MaxNodes);
    localparam int CntW       = $clog2(MaxNodes + 1);
    localparam int WeightBits = 32;
    localparam int CellW      = 2 * NodeW;
    localparam int ThrW       = 16;

    localparam logic [0:0] FUNC_WRITE = 1'b0;
    localparam logic [0:0] FUNC_RUN   = 1'b1;

    localparam logic [0:0] REG_ACTIVE_COUNT   = 1'b0;
    localparam logic [0:0] REG_ZERO_THRESHOLD = 1'b1;

    // per-position flags and owners
    typedef struct packed {
        logic [MaxNodes-1:0]            valid;
        logic [MaxNodes-1:0][NodeW-1:0] owner;
    } t_owner_tbl;
endpackage

// ===== sv/zero_cost_bipartite_matching_top.sv =====
`timescale 1ns / 1ps
// Kuhn maximum bipartite matching over a 16x16 matrix of signed Q16.16
// costs; a cell counts as an edge when its weight is at or below
// zero_threshold. func=0 stores one cell (no result; writes outside the
// active square are dropped). func=1 runs the search and emits one
// transaction per active position, lowest first, the last one flagged
// with the match count. The matrix sits in a 256-entry memory with
// a registered read port; it is cleared after reset by a sweep over all
// entries during which o_ready is low. The search probes one matrix cell
// at a time: S_ADDR addresses it, then S_TEST compares the registered
// data against the threshold, with stack pops in between; the results
// are then emitted in S_OUT. Only one transaction is in flight at a time.
module zero_cost_bipartite_matching_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [0:0]                            i_cfg_index,
    input  logic [zcbm_pkg::ThrW-1:0]             i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_func,
    input  logic [zcbm_pkg::NodeW-1:0]            i_row,
    input  logic [zcbm_pkg::NodeW-1:0]            i_col,
    input  logic signed [zcbm_pkg::WeightBits-1:0] i_weight,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [zcbm_pkg::NodeW-1:0]            o_position,
    output logic [zcbm_pkg::NodeW-1:0]            o_vertex,
    output logic                                  o_matched,
    output logic [zcbm_pkg::CntW-1:0]             o_match_count,
    output logic                                  o_last_item
);
    localparam int NW = zcbm_pkg::NodeW;
    localparam int CW = zcbm_pkg::CntW;
    localparam int WB = zcbm_pkg::WeightBits;
    localparam int TW = zcbm_pkg::ThrW;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ROOT  = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_TEST  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [CW-1:0] r_active;
    logic [zcbm_pkg::ThrW-1:0] r_thr;

    // matrix memory
    logic signed [zcbm_pkg::WeightBits-1:0] mem [0:(1<<zcbm_pkg::CellW)-1];
    logic signed [zcbm_pkg::WeightBits-1:0] r_rdata;
    logic [zcbm_pkg::CellW-1:0] r_clr;
    logic mem_we;
    logic [zcbm_pkg::CellW-1:0] mem_waddr, mem_raddr;
    logic signed [zcbm_pkg::WeightBits-1:0] mem_wdata;

    zcbm_pkg::t_owner_tbl r_own;
    logic [zcbm_pkg::MaxNodes-1:0] r_seen;
    logic [NW-1:0] r_vstk [0:zcbm_pkg::MaxNodes-1];
    logic [CW-1:0] r_cstk [0:zcbm_pkg::MaxNodes-1];
    logic [NW-1:0] r_top;
    logic [CW-1:0] r_root;
    logic [CW-1:0] r_cur;   // cursor of top frame
    logic [NW-1:0] r_k;     // augment walk index
    logic          r_aug;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_cnt;

    logic [CW-1:0] n_eff;
    always_comb begin
        if (r_active == '0) n_eff = CW'(1);
        else if (r_active > CW'(zcbm_pkg::MaxNodes)) n_eff = CW'(zcbm_pkg::MaxNodes);
        else n_eff = r_active;
    end

    logic in_acc, out_acc;
    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign o_valid = (r_state == S_OUT);
    assign out_acc = o_valid && i_ready;

    assign mem_we    = (r_state == S_CLEAR) ||
                       (in_acc && i_func == zcbm_pkg::FUNC_WRITE &&
                        {1'b0, i_row} < n_eff && {1'b0, i_col} < n_eff);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr : {i_row, i_col};
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : i_weight;
    assign mem_raddr = {r_vstk[r_top], r_cur[NW-1:0]};

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[mem_raddr];
    end

    logic edge_ok;
    assign edge_ok = $signed({{TW{r_rdata[WB-1]}}, r_rdata}) <=
                     $signed({{WB{1'b0}}, r_thr});
    logic [NW-1:0] cur_p;
    assign cur_p = r_cur[NW-1:0];

    // position of the frame being written back (cursor holds p + 1)
    logic [CW-1:0] aug_pos;
    assign aug_pos = r_cstk[r_k] - CW'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == '1) n_state = S_IDLE;
            S_IDLE:  if (in_acc && i_func == zcbm_pkg::FUNC_RUN) n_state = S_ROOT;
            S_ROOT:  n_state = (r_root == n_eff) ? S_OUT : S_ADDR;
            S_ADDR: begin
                if (r_aug) begin
                    n_state = (r_k == '0) ? S_ROOT : S_ADDR;
                end else if (r_cur >= n_eff) begin
                    n_state = (r_top == '0) ? S_ROOT : S_ADDR;
                end else if (r_seen[cur_p]) begin
                    n_state = S_ADDR;
                end else begin
                    n_state = S_TEST;
                end
            end
            S_TEST:  n_state = S_ADDR;
            S_OUT:   if (out_acc && r_pos + CW'(1) == n_eff) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_active <= CW'(zcbm_pkg::MaxNodes);
            r_thr    <= '0;
            r_own    <= '0;
            r_seen   <= '0;
            r_aug    <= 1'b0;
            r_top    <= '0;
            r_root   <= '0;
            r_cur    <= '0;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_k      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    zcbm_pkg::REG_ACTIVE_COUNT:   r_active <= i_cfg_data[CW-1:0];
                    zcbm_pkg::REG_ZERO_THRESHOLD: r_thr <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    r_own  <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                    r_pos  <= '0;
                end
                S_ROOT: begin
                    r_seen   <= '0;
                    r_top    <= '0;
                    r_cur    <= '0;
                    r_aug    <= 1'b0;
                    r_vstk[0] <= r_root[NW-1:0];
                end
                S_ADDR: begin
                    if (r_aug) begin
                        // write back path one frame per cycle
                        r_own.valid[aug_pos[NW-1:0]] <= 1'b1;
                        r_own.owner[aug_pos[NW-1:0]] <= r_vstk[r_k];
                        if (r_k == '0) begin
                            r_root  <= r_root + 1'b1;
                            r_cnt   <= r_cnt + 1'b1;
                        end else begin
                            r_k     <= r_k - 1'b1;
                        end
                    end else if (r_cur >= n_eff) begin
                        if (r_top == '0) begin
                            r_root  <= r_root + 1'b1;
                        end else begin
                            r_top   <= r_top - 1'b1;
                            r_cur   <= r_cstk[r_top - 1'b1];
                        end
                    end else if (r_seen[cur_p]) begin
                        r_cur   <= r_cur + 1'b1;
                    end
                end
                S_TEST: begin
                    if (!edge_ok) begin
                        r_cur <= r_cur + 1'b1;
                    end else begin
                        r_seen[cur_p]  <= 1'b1;
                        r_cstk[r_top]  <= r_cur + 1'b1;
                        if (!r_own.valid[cur_p]) begin
                            r_aug <= 1'b1;
                            r_k   <= r_top;
                        end else begin
                            r_top <= r_top + 1'b1;
                            r_vstk[r_top + 1'b1] <= r_own.owner[cur_p];
                            r_cur <= '0;
                        end
                    end
                end
                S_OUT: if (out_acc) r_pos <= r_pos + 1'b1;
                default: ;
            endcase
        end
    end

    logic [NW-1:0] op;
    assign op            = r_pos[NW-1:0];
    assign o_position    = op;
    assign o_matched     = r_own.valid[op];
    assign o_vertex      = r_own.valid[op] ? r_own.owner[op] : '0;
    assign o_last_item   = (r_pos + CW'(1) == n_eff);
    assign o_match_count = o_last_item ? r_cnt : '0;

`ifndef ASSERT_OFF
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEST) |-> !o_ready) else $error("ready during search");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt <= n_eff) else $error("count overflow");
    a_cnt_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones(r_own.valid) == 32'(r_cnt)) else $error("count mismatch");
    a_last_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last_item) |=> o_ready) else $error("no idle after last");
`endif
endmodule

// ===== tb/zcbm_checker.sv =====
`timescale 1ns / 1ps
// Watches the config port and both channels, predicts the matching of
// every run and compares each result transaction in order.
module zcbm_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [0:0]                        i_cfg_index,
    input  logic [zcbm_pkg::ThrW-1:0]         i_cfg_data,
    input  logic                              i_valid,
    input  logic                              i_ready_in,
    input  logic                              i_func,
    input  logic [zcbm_pkg::NodeW-1:0]        i_row,
    input  logic [zcbm_pkg::NodeW-1:0]        i_col,
    input  logic [31:0]                       i_weight,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [zcbm_pkg::NodeW-1:0]        i_position,
    input  logic [zcbm_pkg::NodeW-1:0]        i_vertex,
    input  logic                              i_matched,
    input  logic [zcbm_pkg::CntW-1:0]         i_match_count,
    input  logic                              i_last_item,
    output int                                o_errors,
    output int                                o_pending
);
    typedef struct packed {
        logic [zcbm_pkg::NodeW-1:0] position;
        logic [zcbm_pkg::NodeW-1:0] vertex;
        logic                       matched;
        logic [zcbm_pkg::CntW-1:0]  match_count;
        logic                       last_item;
    } t_slot_result;

    logic signed [31:0]         cost [zcbm_pkg::MaxNodes][zcbm_pkg::MaxNodes];
    logic [4:0]                 active_reg;
    logic [zcbm_pkg::ThrW-1:0]  thr_reg;
    bit                         seen [zcbm_pkg::MaxNodes];
    bit                         owned [zcbm_pkg::MaxNodes];
    logic [zcbm_pkg::NodeW-1:0] owner [zcbm_pkg::MaxNodes];
    int                         span;
    t_slot_result               slots_q [$];

    assign o_pending = slots_q.size();

    function automatic bit is_edge(input int u, input int p);
        return $signed({cost[u][p][31], cost[u][p]}) <= $signed({17'b0, thr_reg});
    endfunction

    // classic recursive Kuhn step, same visiting order as the explicit stack
    function automatic bit try_augment(input int u);
        for (int p = 0; p < span; p++) begin
            if (!seen[p] && is_edge(u, p)) begin
                seen[p] = 1'b1;
                if (!owned[p] || try_augment(int'(owner[p]))) begin
                    owned[p] = 1'b1;
                    owner[p] = u[zcbm_pkg::NodeW-1:0];
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic int eff_span();
        if (active_reg == 0) return 1;
        if (active_reg > zcbm_pkg::MaxNodes) return zcbm_pkg::MaxNodes;
        return int'(active_reg);
    endfunction

    task automatic predict_run();
        t_slot_result r;
        int           total;
        span = eff_span();
        total = 0;
        for (int p = 0; p < zcbm_pkg::MaxNodes; p++) begin
            owned[p] = 1'b0;
            owner[p] = '0;
        end
        for (int v = 0; v < span; v++) begin
            for (int p = 0; p < zcbm_pkg::MaxNodes; p++) seen[p] = 1'b0;
            void'(try_augment(v));
        end
        for (int p = 0; p < span; p++) if (owned[p]) total++;
        for (int p = 0; p < span; p++) begin
            r.position    = p[zcbm_pkg::NodeW-1:0];
            r.vertex      = owned[p] ? owner[p] : '0;
            r.matched     = owned[p];
            r.last_item   = (p == span - 1);
            r.match_count = r.last_item ? total[zcbm_pkg::CntW-1:0] : '0;
            slots_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_slot_result want;
        if (!i_rst_n) begin
            for (int r = 0; r < zcbm_pkg::MaxNodes; r++)
                for (int c = 0; c < zcbm_pkg::MaxNodes; c++) cost[r][c] = '0;
            active_reg = 5'd16;
            thr_reg    = '0;
            o_errors   = 0;
            slots_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == zcbm_pkg::REG_ACTIVE_COUNT) active_reg = i_cfg_data[4:0];
                else if (i_cfg_index == zcbm_pkg::REG_ZERO_THRESHOLD) thr_reg = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (slots_q.size() == 0) begin
                    $display("%0t: unexpected result pos=%0d vtx=%0d m=%0d cnt=%0d last=%0d",
                             $time, i_position, i_vertex, i_matched, i_match_count,
                             i_last_item);
                    o_errors++;
                end else begin
                    want = slots_q.pop_front();
                    if (want != {i_position, i_vertex, i_matched, i_match_count,
                                 i_last_item}) begin
                        $display("%0t: mismatch exp pos=%0d vtx=%0d m=%0d cnt=%0d last=%0d",
                                 $time, want.position, want.vertex, want.matched,
                                 want.match_count, want.last_item);
                        $display("%0t:          got pos=%0d vtx=%0d m=%0d cnt=%0d last=%0d",
                                 $time, i_position, i_vertex, i_matched, i_match_count,
                                 i_last_item);
                        o_errors++;
                    end
                end
            end
            if (i_valid && i_ready_in) begin
                if (i_func == zcbm_pkg::FUNC_RUN) begin
                    predict_run();
                end else begin
                    span = eff_span();
                    // 32-bit weights saturate to themselves
                    if (i_row < span && i_col < span) cost[i_row][i_col] = i_weight;
                end
            end
        end
    end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the zero-cost matching block. Prediction and
// comparison live in zcbm_checker; this module only drives.
module tb;
    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [0:0]                 cfg_index;
    logic [zcbm_pkg::ThrW-1:0]  cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic                       func;
    logic [zcbm_pkg::NodeW-1:0] row;
    logic [zcbm_pkg::NodeW-1:0] col;
    logic signed [31:0]         weight;
    logic                       out_valid;
    logic                       out_ready;
    logic [zcbm_pkg::NodeW-1:0] position;
    logic [zcbm_pkg::NodeW-1:0] vertex;
    logic                       matched;
    logic [zcbm_pkg::CntW-1:0]  match_count;
    logic                       last_item;
    int                         errors;
    int                         pending;

    // idle percentages per side, changed between phases
    int tx_idle;
    int rx_idle;
    // long receiver hold-off: stimulus bumps the request, receiver counts
    int hold_req;
    int hold_seen;
    int hold_left;
    int hold_len;
    // current config, for shaping random cells
    int cur_span;
    int cur_thr;

    zero_cost_bipartite_matching_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_func        (func),
        .i_row         (row),
        .i_col         (col),
        .i_weight      (weight),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_position    (position),
        .o_vertex      (vertex),
        .o_matched     (matched),
        .o_match_count (match_count),
        .o_last_item   (last_item)
    );

    zcbm_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .i_ready_in    (in_ready),
        .i_func        (func),
        .i_row         (row),
        .i_col         (col),
        .i_weight      (weight),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_position    (position),
        .i_vertex      (vertex),
        .i_matched     (matched),
        .i_match_count (match_count),
        .i_last_item   (last_item),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver: random stalls, or a long counted hold-off when requested.
    initial begin
        out_ready = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready = 1'b0;
            end else begin
                out_ready = ($urandom_range(99) >= rx_idle);
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    // One input transaction; called at a falling edge, returns at one.
    // Valid stays up across back-to-back transactions.
    task automatic send(input logic f, input logic [3:0] r, input logic [3:0] c,
                        input logic [31:0] w);
        if ($urandom_range(99) < tx_idle) begin
            in_valid = 1'b0;
            while ($urandom_range(99) < tx_idle) @(negedge clk);
            @(negedge clk);
        end
        in_valid = 1'b1;
        func     = f;
        row      = r;
        col      = c;
        weight   = w;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Register writes only once the block has gone quiet.
    task automatic write_reg(input logic [0:0] idx, input int val);
        drain();
        repeat (8) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val[zcbm_pkg::ThrW-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == zcbm_pkg::REG_ACTIVE_COUNT) begin
            cur_span = int'(val[4:0]);
            if (cur_span == 0) cur_span = 1;
            if (cur_span > zcbm_pkg::MaxNodes) cur_span = zcbm_pkg::MaxNodes;
        end else begin
            cur_thr = int'(val[zcbm_pkg::ThrW-1:0]);
        end
    endtask

    // Weights clustered around the threshold so both edge and non-edge
    // cells show up, plus the raw extremes.
    function automatic logic [31:0] pick_weight();
        case ($urandom_range(7))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return cur_thr;
            4: return cur_thr + 1;
            5: return -$urandom_range(70000);
            6: return $urandom_range(65535);
            default: return 32'd0;
        endcase
    endfunction

    task automatic random_burst(input int count);
        int          pick;
        logic [3:0]  r;
        logic [3:0]  c;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 14 || i == count - 1) begin
                send(zcbm_pkg::FUNC_RUN, 4'($urandom), 4'($urandom), $urandom);
            end else begin
                // mostly cells inside the active square, some outside
                if (pick < 90) begin
                    r = 4'($urandom_range(cur_span - 1));
                    c = 4'($urandom_range(cur_span - 1));
                end else begin
                    r = 4'($urandom);
                    c = 4'($urandom);
                end
                send(zcbm_pkg::FUNC_WRITE, r, c, pick_weight());
            end
        end
    endtask

    initial begin
        int span_set [8];
        int thr_set  [8];
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = zcbm_pkg::REG_ACTIVE_COUNT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        func      = zcbm_pkg::FUNC_WRITE;
        row       = '0;
        col       = '0;
        weight    = '0;
        hold_req  = 0;
        hold_len  = 0;
        tx_idle   = 11;
        rx_idle   = 71;
        cur_span  = zcbm_pkg::MaxNodes;
        cur_thr   = 0;
        span_set = '{16, 1, 0, 31, 5, 9, 16, 2};
        thr_set  = '{0, 65535, 300, 1234, 65535, 0, 65535, 0};
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: all-zero matrix gives the identity-free perfect matching,
        // then extremes, a vertex with no edges, and a contested column.
        send(zcbm_pkg::FUNC_RUN, 4'hf, 4'hf, 32'hffff_ffff);
        send(zcbm_pkg::FUNC_WRITE, 4'd15, 4'd15, 32'h7fff_ffff);
        send(zcbm_pkg::FUNC_WRITE, 4'd0, 4'd15, 32'h8000_0000);
        send(zcbm_pkg::FUNC_WRITE, 4'd3, 4'd4, 32'd1);
        send(zcbm_pkg::FUNC_WRITE, 4'd4, 4'd3, 32'hffff_ffff);
        for (int c = 0; c < 16; c++) send(zcbm_pkg::FUNC_WRITE, 4'd7, c[3:0], 32'd5);
        send(zcbm_pkg::FUNC_RUN, 4'd0, 4'd0, 32'd0);
        write_reg(zcbm_pkg::REG_ZERO_THRESHOLD, 65535);
        send(zcbm_pkg::FUNC_WRITE, 4'd2, 4'd2, 32'h0001_0000);
        send(zcbm_pkg::FUNC_RUN, 4'd0, 4'd0, 32'd0);

        for (int ph = 0; ph < 8; ph++) begin
            // idle pattern: sender light / receiver heavy, swapped, then none
            if (ph < 3) begin
                tx_idle = 11;
                rx_idle = 71;
            end else if (ph < 6) begin
                tx_idle = 71;
                rx_idle = 11;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            write_reg(zcbm_pkg::REG_ACTIVE_COUNT, span_set[ph]);
            write_reg(zcbm_pkg::REG_ZERO_THRESHOLD,
                      (ph == 5) ? $urandom_range(65535) : thr_set[ph]);
            if (ph == 2 || ph == 6) begin
                // receiver backs off for a long stretch while items keep coming
                hold_len = 400;
                hold_req++;
            end
            random_burst(16);
            if (ph == 4) drain();
            random_burst(16);
        end

        drain();
        repeat (50) @(negedge clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
